/* rtl/core/hbsd_pkg.sv */
package hbsd_pkg;

  localparam int CODE_W = 15;
  localparam int LEN_W  = 4;
  localparam int SYM_W  = 8;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [CNT_W-1:0] SYMBOLS_IN_USE_RESET = 5'd16;

  typedef struct packed {
    logic             alive;
    logic             hit;
    logic [SYM_W-1:0] symbol;
  } hbsd_cell_status_t;

endpackage

/* rtl/core/hbsd_cell.sv */
module hbsd_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_en,
  input  logic [hbsd_pkg::CODE_W-1:0]   load_code,
  input  logic [hbsd_pkg::LEN_W-1:0]    load_length,
  input  logic [hbsd_pkg::SYM_W-1:0]    load_symbol,
  input  logic                          step_en,
  input  logic                          in_use,
  input  logic                          code_bit,
  input  logic [hbsd_pkg::LEN_W-1:0]    bit_pos,
  input  logic                          restart,
  output hbsd_pkg::hbsd_cell_status_t   status
);
  import hbsd_pkg::*;

  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  length_r;
  logic [SYM_W-1:0]  symbol_r;
  logic              active_r;
  logic              active_nxt;
  logic [LEN_W-1:0]  sel;
  logic              match_ok;

  // The first transmitted bit sits at the top of the codeword.
  assign sel      = length_r - LEN_W'(1) - bit_pos;
  assign match_ok = active_r && in_use && (bit_pos < length_r) && (code_r[sel] == code_bit);

  assign status.alive  = match_ok;
  assign status.hit    = match_ok && ((bit_pos + LEN_W'(1)) == length_r);
  assign status.symbol = symbol_r;

  always_comb begin
    active_nxt = active_r;
    if (step_en) begin
      if (restart) begin
        active_nxt = 1'b1;
      end else if (in_use) begin
        active_nxt = match_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      code_r   <= load_code;
      length_r <= load_length;
      symbol_r <= load_symbol;
    end
  end

endmodule

/* rtl/core/hbsd_select.sv */
module hbsd_select #(
  parameter int N = 16
) (
  input  hbsd_pkg::hbsd_cell_status_t  status [N],
  output logic                         found,
  output logic                         any_alive,
  output logic [hbsd_pkg::SYM_W-1:0]   symbol
);
  import hbsd_pkg::*;

  // The lowest index that completes its codeword wins.
  always_comb begin
    found     = 1'b0;
    any_alive = 1'b0;
    symbol    = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (status[i].alive) begin
        any_alive = 1'b1;
      end
      if (status[i].hit) begin
        found  = 1'b1;
        symbol = status[i].symbol;
      end
    end
  end

endmodule

/* rtl/core/huffman_bit_serial_decoder_top.sv */
// A request is captured in the input register, then its result in the output register.
// Throughput: one request per cycle unless stalled; all entries compare the bit at once.
// Reset (synchronous, rst_n low): valid flags clear, every entry becomes active,
// the bit position returns to zero and symbols_in_use returns to 16.
// Table contents are not reset and are undefined until loaded.
module huffman_bit_serial_decoder_top #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [hbsd_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [hbsd_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [hbsd_pkg::CODE_W-1:0]  in_entry_code,
  input  logic [hbsd_pkg::LEN_W-1:0]   in_entry_length,
  input  logic [hbsd_pkg::SYM_W-1:0]   in_entry_symbol,
  input  logic                         in_code_bit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hbsd_pkg::SYM_W-1:0]   out_symbol,
  output logic                         out_symbol_valid,
  output logic                         out_stream_error
);
  import hbsd_pkg::*;

  logic [CNT_W-1:0]  sym_in_use_r;
  logic              in_v_r;
  logic              in_mode_r;
  logic [IDX_W-1:0]  in_index_r;
  logic [CODE_W-1:0] in_code_r;
  logic [LEN_W-1:0]  in_length_r;
  logic [SYM_W-1:0]  in_symbol_r;
  logic              in_bit_r;

  logic              out_v_r;
  logic [SYM_W-1:0]  out_symbol_r;
  logic              out_symbol_valid_r;
  logic              out_stream_error_r;

  logic [LEN_W-1:0]  bit_pos_r;
  logic [LEN_W-1:0]  bit_pos_nxt;

  logic              advance;
  logic              step_en;
  logic              found;
  logic              any_alive;
  logic              restart;
  logic [SYM_W-1:0]  sel_symbol;

  hbsd_cell_status_t status [MAX_SYMBOLS];

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign step_en  = advance && (in_mode_r == MODE_DECODE);
  assign restart  = found || !any_alive;

  for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
    hbsd_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .load_en     (advance && (in_mode_r == MODE_LOAD) && (32'(in_index_r) == 32'(i))),
      .load_code   (in_code_r),
      .load_length (in_length_r),
      .load_symbol (in_symbol_r),
      .step_en     (step_en),
      .in_use      (32'(i) < 32'(sym_in_use_r)),
      .code_bit    (in_bit_r),
      .bit_pos     (bit_pos_r),
      .restart     (restart),
      .status      (status[i])
    );
  end

  hbsd_select #(
    .N (MAX_SYMBOLS)
  ) u_select (
    .status    (status),
    .found     (found),
    .any_alive (any_alive),
    .symbol    (sel_symbol)
  );

  always_comb begin
    bit_pos_nxt = bit_pos_r;
    if (step_en) begin
      if (restart) begin
        bit_pos_nxt = '0;
      end else begin
        bit_pos_nxt = bit_pos_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_in_use_r <= SYMBOLS_IN_USE_RESET;
      bit_pos_r    <= '0;
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sym_in_use_r <= cfg_wr_data;
      end
      bit_pos_r <= bit_pos_nxt;
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_mode_r   <= in_mode;
      in_index_r  <= in_entry_index;
      in_code_r   <= in_entry_code;
      in_length_r <= in_entry_length;
      in_symbol_r <= in_entry_symbol;
      in_bit_r    <= in_code_bit;
    end
    if (advance) begin
      if (in_mode_r == MODE_DECODE) begin
        out_symbol_r       <= found ? sel_symbol : '0;
        out_symbol_valid_r <= found;
        out_stream_error_r <= !found && !any_alive;
      end else begin
        out_symbol_r       <= '0;
        out_symbol_valid_r <= 1'b0;
        out_stream_error_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_symbol       = out_symbol_r;
  assign out_symbol_valid = out_symbol_valid_r;
  assign out_stream_error = out_stream_error_r;

`ifndef NO_ASSERTIONS
  a_flags_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_symbol_valid_r && out_stream_error_r))
    else $error("symbol and stream error flagged together");

  a_symbol_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_symbol_valid_r) |-> (out_symbol_r == '0))
    else $error("symbol not zero without a decoded codeword");

  a_restart_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && restart) |=> (bit_pos_r == '0))
    else $error("bit position not cleared after restart");

  a_advance_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall && !advance) |=> (out_v_r && $stable(out_symbol_r)))
    else $error("stalled result lost");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hbsd_pkg::*;

  localparam int MAX_SYMBOLS = 16;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] index;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0] length;
    logic [SYM_W-1:0] sym;
    logic             code_bit;
  } decode_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             hit;
    logic             err;
  } symbol_out_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = MODE_LOAD;
  logic [IDX_W-1:0]  in_entry_index = '0;
  logic [CODE_W-1:0] in_entry_code = '0;
  logic [LEN_W-1:0]  in_entry_length = '0;
  logic [SYM_W-1:0]  in_entry_symbol = '0;
  logic              in_code_bit = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SYM_W-1:0]  out_symbol;
  logic              out_symbol_valid;
  logic              out_stream_error;

  huffman_bit_serial_decoder_top #(.MAX_SYMBOLS(MAX_SYMBOLS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_entry_index   (in_entry_index),
    .in_entry_code    (in_entry_code),
    .in_entry_length  (in_entry_length),
    .in_entry_symbol  (in_entry_symbol),
    .in_code_bit      (in_code_bit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_symbol_valid (out_symbol_valid),
    .out_stream_error (out_stream_error)
  );

  always #6 clk = ~clk;

  // Predictor state, kept apart from the block.
  logic [CODE_W-1:0] tbl_code [MAX_SYMBOLS];
  logic [LEN_W-1:0]  tbl_len  [MAX_SYMBOLS];
  logic [SYM_W-1:0]  tbl_sym  [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] live;
  int unsigned       bit_pos;
  logic [CNT_W-1:0]  in_use_copy;

  // Table as loaded by the stimulus, used to form well-formed streams.
  logic [CODE_W-1:0] stream_code [MAX_SYMBOLS];
  int                stream_len  [MAX_SYMBOLS];

  decode_req_t request_q [$];
  symbol_out_t decoded_q [$];
  int          queued_total = 0;
  int          fail_count = 0;

  decode_req_t nxt;
  decode_req_t seen;
  symbol_out_t want;
  int          burst_left;
  int          gap_left;
  logic [31:0] stall_bits;
  logic [31:0] pat;
  logic [4:0]  stall_phase;

  function automatic symbol_out_t decode_request(input decode_req_t r);
    symbol_out_t o;
    int n;
    int len;
    bit found;
    bit any_live;
    o = '0;
    found = 1'b0;
    any_live = 1'b0;
    if (r.mode == MODE_LOAD) begin
      tbl_code[r.index] = r.code;
      tbl_len[r.index] = r.length;
      tbl_sym[r.index] = r.sym;
      return o;
    end
    n = (in_use_copy > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(in_use_copy);
    for (int i = 0; i < n; i++) begin
      len = int'(tbl_len[i]);
      if (live[i]) begin
        if (bit_pos >= len) begin
          live[i] = 1'b0;
        end else if (tbl_code[i][len - 1 - bit_pos] != r.code_bit) begin
          live[i] = 1'b0;
        end else begin
          if (bit_pos + 1 == len && !found) begin
            found = 1'b1;
            o.symbol = tbl_sym[i];
          end
          any_live = 1'b1;
        end
      end
    end
    if (found) begin
      o.hit = 1'b1;
      live = '1;
      bit_pos = 0;
    end else if (!any_live) begin
      o.err = 1'b1;
      live = '1;
      bit_pos = 0;
    end else begin
      bit_pos = bit_pos + 1;
    end
    return o;
  endfunction

  task automatic queue_load(input int idx, input logic [CODE_W-1:0] code, input int len,
                            input logic [SYM_W-1:0] sym);
    decode_req_t r;
    r.mode = MODE_LOAD;
    r.index = IDX_W'(idx);
    r.code = code;
    r.length = LEN_W'(len);
    r.sym = sym;
    r.code_bit = 1'($urandom_range(0, 1));
    stream_code[idx] = code;
    stream_len[idx] = len;
    request_q.push_back(r);
    queued_total++;
  endtask

  task automatic queue_bit(input logic b);
    decode_req_t r;
    r = decode_req_t'({$urandom, $urandom});
    r.mode = MODE_DECODE;
    r.code_bit = b;
    request_q.push_back(r);
    queued_total++;
  endtask

  task automatic queue_codeword(input int e);
    for (int b = stream_len[e] - 1; b >= 0; b--) queue_bit(stream_code[e][b]);
  endtask

  // Grows a complete prefix code by splitting random leaves, then pads the
  // unused upper code bits with noise.
  task automatic queue_prefix_code();
    logic [CODE_W-1:0] c [MAX_SYMBOLS];
    logic [CODE_W-1:0] pad;
    int l [MAX_SYMBOLS];
    int cnt;
    int j;
    c[0] = '0;
    l[0] = 0;
    cnt = 1;
    while (cnt < MAX_SYMBOLS) begin
      j = $urandom_range(0, cnt - 1);
      c[cnt] = (c[j] << 1) | 1'b1;
      l[cnt] = l[j] + 1;
      c[j] = c[j] << 1;
      l[j] = l[j] + 1;
      cnt++;
    end
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      pad = CODE_W'($urandom);
      queue_load(i, c[i] | (pad << l[i]), l[i], SYM_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (request_q.size() != 0 || in_valid || decoded_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_in_use(input logic [CNT_W-1:0] v);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    in_use_copy = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] v, input int count);
    int stop;
    int nuse;
    int pick;
    set_in_use(v);
    nuse = (v > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(v);
    queue_prefix_code();
    stop = queued_total + count;
    while (queued_total < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_load($urandom_range(0, MAX_SYMBOLS - 1), CODE_W'($urandom),
                   $urandom_range(0, 15), SYM_W'($urandom_range(0, 255)));
      end else if (pick < 18 || nuse == 0) begin
        queue_bit(1'($urandom_range(0, 1)));
      end else begin
        queue_codeword($urandom_range(0, nuse - 1));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        seen = {in_mode, in_entry_index, in_entry_code, in_entry_length, in_entry_symbol,
                in_code_bit};
        decoded_q.push_back(decode_request(seen));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt = request_q.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_entry_index <= nxt.index;
          in_entry_code <= nxt.code;
          in_entry_length <= nxt.length;
          in_entry_symbol <= nxt.sym;
          in_code_bit <= nxt.code_bit;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_bits <= '0;
      stall_phase <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with nothing expected: symbol %0h valid %0b error %0b",
                   $time, out_symbol, out_symbol_valid, out_stream_error);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_symbol !== want.symbol) begin
            $display("%0t: symbol expected %0h actual %0h", $time, want.symbol, out_symbol);
            fail_count++;
          end
          if (out_symbol_valid !== want.hit) begin
            $display("%0t: symbol_valid expected %0b actual %0b", $time, want.hit,
                     out_symbol_valid);
            fail_count++;
          end
          if (out_stream_error !== want.err) begin
            $display("%0t: stream_error expected %0b actual %0b", $time, want.err,
                     out_stream_error);
            fail_count++;
          end
        end
      end
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0: pat = '0;
          1: pat = $urandom;
          2: pat = $urandom & $urandom;
          default: pat = $urandom | $urandom;
        endcase
        out_stall <= pat[0];
        stall_bits <= pat >> 1;
      end else begin
        out_stall <= stall_bits[0];
        stall_bits <= stall_bits >> 1;
      end
      stall_phase <= stall_phase + 1'b1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      tbl_code[i] = '0;
      tbl_len[i] = '0;
      tbl_sym[i] = '0;
      stream_code[i] = '0;
      stream_len[i] = 0;
    end
    live = '1;
    bit_pos = 0;
    in_use_copy = SYMBOLS_IN_USE_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Four entries in use: a duplicated one-bit code where the lower index must
    // win, a zero-length entry, and a fifteen-bit code of ones.
    set_in_use(5'd4);
    queue_load(0, 15'h7FFE, 1, 8'hFF);
    queue_load(1, 15'h0000, 1, 8'h00);
    queue_load(2, 15'h7FFF, 0, 8'h5A);
    queue_load(3, 15'h7FFF, 15, 8'hA5);
    queue_load(15, 15'h0000, 15, 8'h3C);
    queue_bit(1'b0);
    queue_bit(1'b1);
    queue_bit(1'b0);
    repeat (7) queue_bit(1'b1);
    queue_load(15, 15'h7FFF, 15, 8'hC3);
    repeat (8) queue_bit(1'b1);

    run_phase(5'd16, 56);
    run_phase(5'd2, 56);
    run_phase(5'd31, 56);
    run_phase(5'd0, 56);
    run_phase(5'd1, 56);
    run_phase(5'd9, 56);
    run_phase(5'd17, 56);
    run_phase(5'd16, 56);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
